@@ rtl/core/ddsfe_pkg.sv @@
// Shared types, frame constants and CRC helpers for the speed frame encoder.
`timescale 1ns / 1ps
package ddsfe_pkg;

	localparam int unsigned COEFF_W = 24;
	localparam int unsigned FRAME_LEN = 16;
	localparam int unsigned IDX_W = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] HDR0 = 8'hAA;
	localparam logic [7:0] HDR1 = 8'h20;
	localparam logic [7:0] HDR2 = 8'h20;
	localparam logic [7:0] HDR3 = 8'h3A;
	localparam logic [7:0] HDR4 = 8'h08;
	localparam logic [7:0] TERM = 8'h0D;

	localparam logic [COEFF_W-1:0] SPEED_COEFF_RST = 24'd500658;
	localparam logic [COEFF_W-1:0] YAW_COEFF_RST = 24'd18650;

	typedef enum logic [0:0] {
		CFG_SPEED_COEFF = 1'b0,
		CFG_YAW_COEFF   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
	} wheel_t;

	typedef struct packed {
		wheel_t      wheel;
		logic [15:0] crc;
	} frame_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	localparam logic [15:0] HDR_CRC =
		crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, HDR0), HDR1), HDR2), HDR3), HDR4);

endpackage

@@ rtl/core/ddsfe_kin.sv @@
// Wheel speed pipeline: multiply, sum and difference, truncate and saturate.
`timescale 1ns / 1ps
module ddsfe_kin (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  logic signed [15:0]             linear_speed,
	input  logic signed [15:0]             yaw_rate,
	input  logic [ddsfe_pkg::COEFF_W-1:0]  speed_coeff,
	input  logic [ddsfe_pkg::COEFF_W-1:0]  yaw_coeff,
	output logic                           wheel_valid,
	output ddsfe_pkg::wheel_t              wheel
);

	logic               v_s1, v_s2, v_s3;
	logic signed [40:0] sv_s1, yw_s1;
	logic signed [41:0] sum_s2, rdif_s2;
	ddsfe_pkg::wheel_t  wheel_s3;

	function automatic logic [15:0] trunc_sat(input logic signed [41:0] x);
		logic signed [41:0] b;
		logic signed [25:0] q;
		b = x[41] ? (x + 42'sd65535) : x;
		q = 26'(b >>> 16);
		if (q > 26'sd32767) begin
			return 16'h7FFF;
		end else if (q < -26'sd32768) begin
			return 16'h8000;
		end else begin
			return q[15:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sv_s1    <= $signed({1'b0, speed_coeff}) * linear_speed;
			yw_s1    <= $signed({1'b0, yaw_coeff}) * yaw_rate;
			sum_s2   <= $signed({sv_s1[40], sv_s1}) + $signed({yw_s1[40], yw_s1});
			rdif_s2  <= $signed({yw_s1[40], yw_s1}) - $signed({sv_s1[40], sv_s1});
			wheel_s3 <= '{left: trunc_sat(sum_s2), right: trunc_sat(rdif_s2)};
		end
	end

	assign wheel_valid = v_s3;
	assign wheel       = wheel_s3;

endmodule

@@ rtl/core/ddsfe_crc.sv @@
// CRC pipeline: folds the eight wheel bytes into the header CRC, two bytes a stage.
`timescale 1ns / 1ps
module ddsfe_crc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              wheel_valid,
	input  ddsfe_pkg::wheel_t wheel,
	output logic              frame_valid,
	output ddsfe_pkg::frame_t frame
);

	logic              v_s4, v_s5, v_s6, v_s7;
	ddsfe_pkg::frame_t f_s4, f_s5, f_s6, f_s7;

	function automatic logic [15:0] crc_word(input logic [15:0] c, input logic [15:0] w);
		return ddsfe_pkg::crc_byte(ddsfe_pkg::crc_byte(c, w[7:0]), w[15:8]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s4 <= wheel_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4.wheel <= wheel;
			f_s4.crc   <= crc_word(ddsfe_pkg::HDR_CRC, wheel.left);
			f_s5.wheel <= f_s4.wheel;
			f_s5.crc   <= crc_word(f_s4.crc, f_s4.wheel.right);
			f_s6.wheel <= f_s5.wheel;
			f_s6.crc   <= crc_word(f_s5.crc, f_s5.wheel.right);
			f_s7.wheel <= f_s6.wheel;
			f_s7.crc   <= crc_word(f_s6.crc, f_s6.wheel.left);
		end
	end

	assign frame_valid = v_s7;
	assign frame       = f_s7;

endmodule

@@ rtl/core/ddsfe_ser.sv @@
// Frame serializer: holds one finished frame and sends it one byte per cycle while out_stall is low.
`timescale 1ns / 1ps
module ddsfe_ser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frame_valid,
	input  ddsfe_pkg::frame_t            frame,
	output logic                         take,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   frame_byte,
	output logic [ddsfe_pkg::IDX_W-1:0]  byte_index,
	output logic                         frame_last
);

	logic                        fv_q;
	logic [ddsfe_pkg::IDX_W-1:0] idx_q;
	ddsfe_pkg::frame_t           frame_q;
	logic                        last;

	assign last = (idx_q == ddsfe_pkg::LAST_IDX);
	assign take = !fv_q || (last && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q  <= 1'b0;
			idx_q <= '0;
		end else if (fv_q && !out_stall && !last) begin
			idx_q <= idx_q + 1'b1;
		end else if (take) begin
			fv_q  <= frame_valid;
			idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && frame_valid) begin
			frame_q <= frame;
		end
	end

	always_comb begin
		unique case (idx_q)
			4'd0:    frame_byte = ddsfe_pkg::HDR0;
			4'd1:    frame_byte = ddsfe_pkg::HDR1;
			4'd2:    frame_byte = ddsfe_pkg::HDR2;
			4'd3:    frame_byte = ddsfe_pkg::HDR3;
			4'd4:    frame_byte = ddsfe_pkg::HDR4;
			4'd5:    frame_byte = frame_q.wheel.left[7:0];
			4'd6:    frame_byte = frame_q.wheel.left[15:8];
			4'd7:    frame_byte = frame_q.wheel.right[7:0];
			4'd8:    frame_byte = frame_q.wheel.right[15:8];
			4'd9:    frame_byte = frame_q.wheel.right[7:0];
			4'd10:   frame_byte = frame_q.wheel.right[15:8];
			4'd11:   frame_byte = frame_q.wheel.left[7:0];
			4'd12:   frame_byte = frame_q.wheel.left[15:8];
			4'd13:   frame_byte = frame_q.crc[7:0];
			4'd14:   frame_byte = frame_q.crc[15:8];
			default: frame_byte = ddsfe_pkg::TERM;
		endcase
	end

	assign out_valid  = fv_q;
	assign byte_index = idx_q;
	assign frame_last = last;

endmodule

@@ rtl/core/diff_drive_speed_frame_encoder_unit.sv @@
// Top level of the differential-drive speed frame encoder.
// Path: kinematics stages s1 to s3, CRC stages s4 to s7, then the serializer, which sends bytes 0 to 15.
// The serializer sends one byte per cycle while out_stall is low and takes the next frame as its last byte goes.
// The seven pipeline stages advance only while the serializer is empty or sends its last byte unstalled.
// Reset: clears all valid bits and the byte counter, loads the default gains.
`timescale 1ns / 1ps
module diff_drive_speed_frame_encoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            linear_speed,
	input  logic signed [15:0]            yaw_rate,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    frame_byte,
	output logic [ddsfe_pkg::IDX_W-1:0]   byte_index,
	output logic                          frame_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [ddsfe_pkg::COEFF_W-1:0] cfg_data
);

	logic [ddsfe_pkg::COEFF_W-1:0] speed_coeff_q, yaw_coeff_q;
	logic                          adv;
	logic                          wheel_valid, frame_valid;
	ddsfe_pkg::wheel_t             wheel;
	ddsfe_pkg::frame_t             frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_coeff_q <= ddsfe_pkg::SPEED_COEFF_RST;
			yaw_coeff_q   <= ddsfe_pkg::YAW_COEFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ddsfe_pkg::cfg_idx_t'(cfg_index))
				ddsfe_pkg::CFG_SPEED_COEFF: speed_coeff_q <= cfg_data;
				ddsfe_pkg::CFG_YAW_COEFF:   yaw_coeff_q   <= cfg_data;
				default:                    ;
			endcase
		end
	end

	assign in_stall = !adv;

	ddsfe_kin u_kin (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.linear_speed (linear_speed),
		.yaw_rate     (yaw_rate),
		.speed_coeff  (speed_coeff_q),
		.yaw_coeff    (yaw_coeff_q),
		.wheel_valid  (wheel_valid),
		.wheel        (wheel)
	);

	ddsfe_crc u_crc (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.wheel_valid (wheel_valid),
		.wheel       (wheel),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

	ddsfe_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame       (frame),
		.take        (adv),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.byte_index  (byte_index),
		.frame_last  (frame_last)
	);

	a_byte_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !frame_last |=>
			out_valid && byte_index == ddsfe_pkg::IDX_W'($past(byte_index) + 1'b1))
		else $error("byte index did not advance within a frame");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_last && frame_valid |=>
			out_valid && byte_index == '0)
		else $error("pending frame not started after terminator");

	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty serializer");

	a_header_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == '0 |-> frame_byte == ddsfe_pkg::HDR0)
		else $error("frame does not open with the header byte");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the differential-drive speed frame encoder.
`timescale 1ns / 1ps
module tb_top;
	import ddsfe_pkg::*;

	typedef struct {
		logic signed [15:0] speed;
		logic signed [15:0] yaw;
	} drive_cmd_t;

	typedef struct {
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             last;
	} frame_byte_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [15:0]       linear_speed;
	logic signed [15:0]       yaw_rate;
	logic                     out_valid;
	logic                     out_stall;
	logic [7:0]               frame_byte;
	logic [IDX_W-1:0]         byte_index;
	logic                     frame_last;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [0:0]               cfg_index;
	logic [COEFF_W-1:0]       cfg_data;

	logic [COEFF_W-1:0] speed_gain = SPEED_COEFF_RST;
	logic [COEFF_W-1:0] yaw_gain   = YAW_COEFF_RST;

	drive_cmd_t  cmd_q[$];
	frame_byte_t frame_bytes_due[$];

	int  n_queued     = 0;
	int  n_accepted   = 0;
	int  n_bytes      = 0;
	int  n_gain_sets  = 1;
	int  mismatches   = 0;
	logic in_fire     = 1'b0;
	int  burst_left   = 0;
	int  gap_left     = 0;
	int  stall_mode   = 0;
	int  stall_run    = 0;
	logic stall_off   = 1'b0;
	drive_cmd_t  next_cmd;
	frame_byte_t got;

	diff_drive_speed_frame_encoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.linear_speed (linear_speed),
		.yaw_rate     (yaw_rate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.byte_index   (byte_index),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [15:0] clamp_wheel(input longint x);
		if (x > 32767) return 16'h7FFF;
		if (x < -32768) return 16'h8000;
		return x[15:0];
	endfunction

	// Wheel kinematics, frame assembly and CRC-16 for one command.
	task automatic encode_frame(input logic signed [15:0] v, input logic signed [15:0] w);
		longint      sv;
		longint      yw;
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] crc;
		logic [7:0]  f[FRAME_LEN];
		frame_byte_t e;
		sv = longint'(speed_gain) * longint'(v);
		yw = longint'(yaw_gain) * longint'(w);
		left = clamp_wheel((sv + yw) / 65536);
		right = clamp_wheel(-((sv - yw) / 65536));
		f[0] = HDR0; f[1] = HDR1; f[2] = HDR2; f[3] = HDR3; f[4] = HDR4;
		f[5] = left[7:0];  f[6] = left[15:8];
		f[7] = right[7:0]; f[8] = right[15:8];
		f[9] = right[7:0]; f[10] = right[15:8];
		f[11] = left[7:0]; f[12] = left[15:8];
		crc = 16'h0000;
		for (int i = 0; i < 13; i++) begin
			crc = crc ^ {f[i], 8'h00};
			for (int b = 0; b < 8; b++) begin
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
			end
		end
		f[13] = crc[7:0];
		f[14] = crc[15:8];
		f[15] = TERM;
		for (int k = 0; k < FRAME_LEN; k++) begin
			e.data = f[k];
			e.idx = IDX_W'(k);
			e.last = (k == FRAME_LEN - 1);
			frame_bytes_due.push_back(e);
		end
	endtask

	// Monitor: predict on accepted requests, check accepted bytes, track gain writes.
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				encode_frame(linear_speed, yaw_rate);
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				n_bytes++;
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h index %0d",
						frame_byte, byte_index));
				end else begin
					got = frame_bytes_due.pop_front();
					if (frame_byte !== got.data)
						report_mismatch($sformatf("frame_byte %02h, want %02h at index %0d",
							frame_byte, got.data, got.idx));
					if (byte_index !== got.idx)
						report_mismatch($sformatf("byte_index %0d, want %0d",
							byte_index, got.idx));
					if (frame_last !== got.last)
						report_mismatch($sformatf("frame_last %0b, want %0b at index %0d",
							frame_last, got.last, got.idx));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SPEED_COEFF: speed_gain = cfg_data;
					CFG_YAW_COEFF:   yaw_gain = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Driver: bursts of requests separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (in_fire || !in_valid)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				next_cmd = cmd_q.pop_front();
				linear_speed <= next_cmd.speed;
				yaw_rate <= next_cmd.yaw;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 8);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 3);
						2: gap_left = $urandom_range(4, 20);
						default: gap_left = $urandom_range(21, 50);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: alternate free, light, heavy and solid stretches.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = (stall_mode == 3) ? $urandom_range(1, 24) : $urandom_range(4, 60);
		end
		stall_run--;
		if (stall_off) begin
			out_stall <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'b1;
			endcase
		end
	end

	task automatic queue_cmd(input logic signed [15:0] v, input logic signed [15:0] w);
		drive_cmd_t c;
		c.speed = v;
		c.yaw = w;
		cmd_q.push_back(c);
		n_queued++;
	endtask

	function automatic logic signed [15:0] rand_rate();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 600)) - 300);
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return 16'sh0001;
				endcase
			end
			3: return 16'(int'($urandom_range(0, 8000)) - 4000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [COEFF_W-1:0] rand_gain();
		case ($urandom_range(0, 3))
			0: return COEFF_W'($urandom);
			1: return COEFF_W'($urandom_range(0, 24'h3FFFF));
			2: return COEFF_W'($urandom_range(0, 24'h00FFF));
			default: return COEFF_W'($urandom_range(24'h010000, 24'h200000));
		endcase
	endfunction

	task automatic wait_drained();
		while (!(n_accepted == n_queued && frame_bytes_due.size() == 0)) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_gain(input cfg_idx_t idx, input logic [COEFF_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_gains(input logic [COEFF_W-1:0] sg, input logic [COEFF_W-1:0] yg);
		wait_drained();
		write_gain(CFG_SPEED_COEFF, sg);
		write_gain(CFG_YAW_COEFF, yg);
		n_gain_sets++;
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) queue_cmd(rand_rate(), rand_rate());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		linear_speed = '0;
		yaw_rate = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SPEED_COEFF;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default gains: extremes, saturation and truncation toward zero
		queue_cmd(16'sd0, 16'sd0);
		queue_cmd(16'sh7FFF, 16'sd0);
		queue_cmd(16'sh8000, 16'sd0);
		queue_cmd(16'sd0, 16'sh7FFF);
		queue_cmd(16'sd0, 16'sh8000);
		queue_cmd(16'sh7FFF, 16'sh7FFF);
		queue_cmd(16'sh8000, 16'sh8000);
		queue_cmd(16'sh7FFF, 16'sh8000);
		queue_cmd(16'sh8000, 16'sh7FFF);
		queue_cmd(16'sd1, 16'sd0);
		queue_cmd(-16'sd1, 16'sd0);
		queue_cmd(16'sd0, 16'sd1);
		queue_cmd(16'sd0, -16'sd1);
		queue_cmd(-16'sd1, -16'sd1);
		queue_cmd(-16'sd3, 16'sd5);
		queue_cmd(16'sd4285, -16'sd100);
		queue_cmd(-16'sd4286, 16'sd3000);
		queue_random(50);

		set_gains(24'hFFFFFF, 24'hFFFFFF);
		queue_cmd(16'sd1, -16'sd1);
		queue_cmd(-16'sd1, 16'sd1);
		queue_cmd(16'sh7FFF, 16'sh7FFF);
		queue_random(40);

		set_gains(24'h000000, 24'h000000);
		queue_random(30);

		set_gains(24'h000001, 24'h000001);
		queue_random(30);

		for (int p = 0; p < 6; p++) begin
			set_gains(rand_gain(), rand_gain());
			queue_random(50);
		end

		wait_drained();
		stall_off = 1'b1;
		wait_drained();

		$display("Encoded %0d commands under %0d gain settings; %0d frame bytes checked.",
			n_accepted, n_gain_sets, n_bytes);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ddsfe_pkg.sv
rtl/core/ddsfe_kin.sv
rtl/core/ddsfe_crc.sv
rtl/core/ddsfe_ser.sv
rtl/core/diff_drive_speed_frame_encoder_unit.sv
tb/tb_top.sv
